### design/assert_macros.svh
// assertion helpers used by the rtl file lva_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

### design/lva_pkg.sv
package lva_pkg;

  // default sizes
  localparam int VOICE_COUNT_DEF = 16;
  localparam int ZONE_SLOTS_DEF  = 6;

  // zone word: low note, high note, low vel, high vel (7 bits each)
  localparam int ZONE_WORD_W = 28;
  localparam logic [ZONE_WORD_W-1:0] ZONE_WORD_RESET = 28'd266354560;

  // configuration register indexes
  localparam logic [2:0] REG_ZONE_COUNT = 3'd0;
  localparam logic [2:0] REG_ZONE_WORD0 = 3'd1;

  // input function codes
  typedef enum logic [2:0] {
    FN_NOTE_ON    = 3'd0,
    FN_NOTE_OFF   = 3'd1,
    FN_ALL_OFF    = 3'd2,
    FN_VOICE_DONE = 3'd3,
    FN_CLEAR      = 3'd4
  } func_t;

  // result action codes
  typedef enum logic [2:0] {
    ACT_IGNORED = 3'd0,
    ACT_TAKE    = 3'd1,
    ACT_RETRIG  = 3'd2,
    ACT_STEAL   = 3'd3,
    ACT_RELEASE = 3'd4
  } action_t;

  // one result beat
  typedef struct packed {
    action_t     action;
    logic [3:0]  voice_index;
    logic [2:0]  zone_index;
    logic [6:0]  stolen_note;
    logic [15:0] release_mask;
  } result_t;

endpackage

### design/lva_ram.sv
module lva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/lva_core.sv
`include "assert_macros.svh"

module lva_core #(
  parameter int VOICE_COUNT = lva_pkg::VOICE_COUNT_DEF,
  parameter int ZONE_SLOTS  = lva_pkg::ZONE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_func,
  input  logic [6:0]          in_note,
  input  logic [6:0]          in_vel,
  input  logic [3:0]          in_done,
  input  logic [2:0]          zone_count,
  input  logic [ZONE_SLOTS-1:0][lva_pkg::ZONE_WORD_W-1:0] zone_words,
  input  logic                out_free,
  output logic                res_valid,
  output lva_pkg::result_t    res
);

  localparam int VIW = $clog2(VOICE_COUNT);
  localparam int ZIW = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
  localparam int MW  = (VOICE_COUNT > 16) ? VOICE_COUNT : 16;
  localparam int RW  = 7 + 32;
  localparam logic [VIW-1:0] LAST_VOICE = VIW'(VOICE_COUNT - 1);

  typedef enum logic [2:0] {S_IDLE, S_ZONE, S_SCAN, S_DECIDE, S_DONE} state_t;

  state_t state;

  // latched item
  logic [2:0] func;
  logic [6:0] note;
  logic [6:0] vel;

  // zone search and voice scan
  logic [ZIW-1:0] zi;
  logic           issuing;
  logic [VIW-1:0] ra;
  logic           chk_v;
  logic [VIW-1:0] chk_idx;
  logic           hit_found;
  logic [VIW-1:0] hit_idx;
  logic           free_found;
  logic [VIW-1:0] free_idx;
  logic [31:0]    min_stamp;
  logic [VIW-1:0] min_idx;
  logic [6:0]     min_note;
  logic [15:0]    mask;
  logic           any_rel;

  // voice state
  logic [VOICE_COUNT-1:0] busy;
  logic [31:0]            use_counter;

  // ram of note and stamp per voice
  logic           ram_we;
  logic [VIW-1:0] pick;
  logic [RW-1:0]  ram_wdata;
  logic [RW-1:0]  ram_rdata;
  logic [6:0]     rd_note;
  logic [31:0]    rd_stamp;

  lva_ram #(
    .WIDTH (RW),
    .DEPTH (VOICE_COUNT)
  ) u_voice_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pick),
    .wdata (ram_wdata),
    .raddr (ra),
    .rdata (ram_rdata)
  );

  assign rd_note  = ram_rdata[6:0];
  assign rd_stamp = ram_rdata[RW-1:7];

  // zone range check on the selected zone word
  logic [lva_pkg::ZONE_WORD_W-1:0] zw;
  logic [2:0]                      limit;
  logic                            zone_holds;
  logic                            zone_last;

  assign zw    = zone_words[zi];
  assign limit = (zone_count > 3'(ZONE_SLOTS)) ? 3'(ZONE_SLOTS) : zone_count;
  assign zone_holds = (note >= zw[6:0]) && (note <= zw[13:7]) &&
                      (vel >= zw[20:14]) && (vel <= zw[27:21]);
  assign zone_last  = (3'(zi) == (limit - 3'd1));

  // immediate checks on the incoming item
  logic [MW-1:0] busy_wide;
  logic [MW-1:0] busy_shift;
  logic          done_busy;

  assign busy_wide  = MW'(busy);
  assign busy_shift = busy_wide >> in_done;
  assign done_busy  = (32'(in_done) < VOICE_COUNT) && busy_shift[0];

  // result of the items answered without a scan
  lva_pkg::result_t idle_res;
  always_comb begin
    idle_res = '0;
    if ((in_func == lva_pkg::FN_ALL_OFF) || (in_func == lva_pkg::FN_CLEAR)) begin
      idle_res.action       = (|busy) ? lva_pkg::ACT_RELEASE : lva_pkg::ACT_IGNORED;
      idle_res.release_mask = busy_wide[15:0];
    end else if ((in_func == lva_pkg::FN_VOICE_DONE) && done_busy) begin
      idle_res.action       = lva_pkg::ACT_RELEASE;
      idle_res.release_mask = 16'(1) << in_done;
    end
  end

  // per-entry scan flags
  logic busy_i;
  logic note_eq;
  assign busy_i  = busy[chk_idx];
  assign note_eq = busy_i && (rd_note == note);

  // allocation choice after the scan
  lva_pkg::action_t act;
  always_comb begin
    priority if (hit_found) begin
      pick = hit_idx;
      act  = lva_pkg::ACT_RETRIG;
    end else if (free_found) begin
      pick = free_idx;
      act  = lva_pkg::ACT_TAKE;
    end else begin
      pick = min_idx;
      act  = lva_pkg::ACT_STEAL;
    end
  end

  assign ram_we    = (state == S_DECIDE) && (func == lva_pkg::FN_NOTE_ON);
  assign ram_wdata = {use_counter + 32'd1, note};

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE) && out_free;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      busy        <= '0;
      use_counter <= '0;
      issuing     <= 1'b0;
      chk_v       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            func       <= in_func;
            note       <= in_note;
            vel        <= in_vel;
            zi         <= '0;
            ra         <= '0;
            chk_v      <= 1'b0;
            issuing    <= (in_func == lva_pkg::FN_NOTE_OFF);
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            mask       <= '0;
            any_rel    <= 1'b0;
            res        <= idle_res;
            unique case (in_func)
              lva_pkg::FN_NOTE_ON: begin
                if (limit == 3'd0) begin
                  state <= S_DONE;
                end else begin
                  state <= S_ZONE;
                end
              end
              lva_pkg::FN_NOTE_OFF: begin
                state <= S_SCAN;
              end
              lva_pkg::FN_ALL_OFF, lva_pkg::FN_CLEAR: begin
                if (in_func == lva_pkg::FN_CLEAR) begin
                  busy <= '0;
                end
                state <= S_DONE;
              end
              lva_pkg::FN_VOICE_DONE: begin
                if (done_busy) begin
                  busy[VIW'(in_done)] <= 1'b0;
                end
                state <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        S_ZONE: begin
          if (zone_holds) begin
            issuing <= 1'b1;
            state   <= S_SCAN;
          end else if (zone_last) begin
            state <= S_DONE;
          end else begin
            zi <= zi + ZIW'(1);
          end
        end

        S_SCAN: begin
          // address issue runs ahead of the check, which comes in the cycle after each issue
          if (issuing) begin
            ra <= ra + VIW'(1);
            if (ra == LAST_VOICE) begin
              issuing <= 1'b0;
            end
          end
          chk_v   <= issuing;
          chk_idx <= ra;
          if (chk_v) begin
            if (note_eq) begin
              any_rel <= 1'b1;
              mask    <= mask | (16'(1) << chk_idx);
              if (!hit_found) begin
                hit_found <= 1'b1;
                hit_idx   <= chk_idx;
              end
            end
            if (!busy_i && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= chk_idx;
            end
            // running minimum of use stamps, lowest index wins ties
            if ((chk_idx == '0) || (rd_stamp < min_stamp)) begin
              min_stamp <= rd_stamp;
              min_idx   <= chk_idx;
              min_note  <= rd_note;
            end
            if (chk_idx == LAST_VOICE) begin
              state <= S_DECIDE;
            end
          end
        end

        S_DECIDE: begin
          if (func == lva_pkg::FN_NOTE_ON) begin
            use_counter      <= use_counter + 32'd1;
            busy[pick]       <= 1'b1;
            res.action       <= act;
            res.voice_index  <= 4'(pick);
            res.zone_index   <= 3'(zi);
            res.stolen_note  <= (act == lva_pkg::ACT_STEAL) ? min_note : 7'd0;
          end else begin
            res.action       <= any_rel ? lva_pkg::ACT_RELEASE : lva_pkg::ACT_IGNORED;
            res.release_mask <= mask;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `ASSERT_PROP(a_scan_func, clk, rst, (state == S_SCAN) |-> (func == lva_pkg::FN_NOTE_ON || func == lva_pkg::FN_NOTE_OFF), "voice scan for a function that needs none")
  `ASSERT_PROP(a_steal_full, clk, rst, (state == S_DECIDE && func == lva_pkg::FN_NOTE_ON && !hit_found && !free_found) |-> (&busy), "steal chosen while a voice is free")
  `ASSERT_PROP(a_retrig_busy, clk, rst, (state == S_DECIDE && func == lva_pkg::FN_NOTE_ON && hit_found) |-> busy[hit_idx], "retrigger of a free voice")
  `ASSERT_PROP(a_stamp_step, clk, rst, (!$past(rst) && use_counter != $past(use_counter)) |-> ($past(state) == S_DECIDE && $past(func) == lva_pkg::FN_NOTE_ON), "use stamp moved outside a note on")

endmodule

### design/lru_voice_allocator.sv
// input beat to result valid: a note on searches the zones in order and, on a match, scans
//   the voices one per cycle and decides; a note off scans and decides; an unmatched note
//   on ends after the zone search; all off, clear, voice done and unknown skip the scan
// throughput: one item at a time; the next beat is taken while the result waits in the
//   output register
// rst (synchronous, active high): voices free, stamp counter and zone count zero, full zones
module lru_voice_allocator #(
  parameter int VOICE_COUNT = lva_pkg::VOICE_COUNT_DEF,
  parameter int ZONE_SLOTS  = lva_pkg::ZONE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // note_number[6:0], note_velocity[13:7], done_voice[17:14]
  input  logic [2:0]  s_tuser,   // func[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // voice_index[3:0], zone_index[6:4], stolen_note[13:7],
                                 // release_mask[29:14]
  output logic [2:0]  m_tuser,   // action[2:0]
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [27:0] cfg_data
);

  localparam int ZIW = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
  localparam logic [3:0] ZONE_REG_END = 4'(32'(lva_pkg::REG_ZONE_WORD0) + ZONE_SLOTS);

  logic [2:0]                                      zone_count;
  logic [ZONE_SLOTS-1:0][lva_pkg::ZONE_WORD_W-1:0] zone_words;
  logic [2:0]                                      zone_sel;

  assign zone_sel = cfg_index - lva_pkg::REG_ZONE_WORD0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_count <= '0;
      for (int i = 0; i < ZONE_SLOTS; i++) begin
        zone_words[i] <= lva_pkg::ZONE_WORD_RESET;
      end
    end else if (cfg_wen) begin
      if (cfg_index == lva_pkg::REG_ZONE_COUNT) begin
        zone_count <= cfg_data[2:0];
      end else if ({1'b0, cfg_index} < ZONE_REG_END) begin
        zone_words[ZIW'(zone_sel)] <= cfg_data;
      end
    end
  end

  logic             out_free;
  logic             res_valid;
  lva_pkg::result_t res;
  lva_pkg::result_t out_res;

  assign out_free = !m_tvalid || m_tready;

  lva_core #(
    .VOICE_COUNT (VOICE_COUNT),
    .ZONE_SLOTS  (ZONE_SLOTS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_func    (s_tuser),
    .in_note    (s_tdata[6:0]),
    .in_vel     (s_tdata[13:7]),
    .in_done    (s_tdata[17:14]),
    .zone_count (zone_count),
    .zone_words (zone_words),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.action;
  assign m_tdata = {2'b00, out_res.release_mask, out_res.stolen_note,
                    out_res.zone_index, out_res.voice_index};

endmodule
